// ===== rtl/ccs_pkg.sv =====
// Shared types and constants for the comment stripper.
`timescale 1ns / 1ps

package ccs_pkg;

  // Characters the scanner reacts to.
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChSlash  = 8'h2F;

  // Output queue sizing: room for two pushes beyond two waiting entries.
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // Scanner state.
  typedef struct packed {
    logic ins;    // inside a double-quoted string
    logic esc;    // backslash escape pending in string
    logic line;   // inside a line comment
    logic blk;    // inside a block comment
    logic held;   // a slash waits for the next byte
    logic star;   // previous block-comment byte was a star
  } ccs_state_t;

  // One result item.
  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       eot;
  } ccs_result_t;

  // Results produced by one request: count 0..2 and the items in order.
  typedef struct packed {
    logic [1:0]  n;
    ccs_result_t r0;
    ccs_result_t r1;
  } ccs_push_t;

endpackage

// ===== rtl/c_comment_stripper.sv =====
// Top level of the C/C++ comment stripper.
`timescale 1ns / 1ps

// Streams source text one byte per request and passes it on with C block
// comments and C++ line comments removed. A line comment is dropped up to and
// including its newline; a block comment through its closing star-slash. With
// strings_aware set (reset value 1), double-quoted strings pass untouched,
// backslash escapes included, so comment markers inside them survive; character
// literals get no special handling. A lone slash is held until the next byte
// shows whether a comment starts, and is then released ahead of that byte, so
// one input byte can give two results. On the byte marked last, a held slash is
// flushed and the final result carries end_of_text; if that byte gave nothing,
// a bare marker (byte_valid 0, out_byte 0) is sent. All scanner state then
// resets, so an open comment or string ends with the text.
// Rate: one input byte per cycle while the result queue has room. Each request
// is held in the input register and then written into the four-entry result
// queue, whose head drives the output. The queue only takes
// a request when two entries are free; a two-result byte can therefore cause
// backpressure when the output is draining one per cycle.
// Write strings_aware over the cfg channel only while no text is in flight.
module c_comment_stripper import ccs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration write
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_strings_aware_i,
  // input text
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  // stripped text
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       end_of_text_o
);

  logic        strings_aware_q;
  logic        room;
  ccs_push_t   push;
  ccs_result_t head;

  // The register accepts a write in any cycle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strings_aware_q <= 1'b1;
    end else if (cfg_valid_i) begin
      strings_aware_q <= cfg_strings_aware_i;
    end
  end

  ccs_step u_step (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .strings_aware_i (strings_aware_q),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_byte_i       (in_byte_i),
    .in_last_i       (in_last_i),
    .room_i          (room),
    .push_o          (push)
  );

  ccs_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (head)
  );

  assign out_byte_o    = head.data;
  assign byte_valid_o  = head.byte_valid;
  assign end_of_text_o = head.eot;

endmodule

// ===== rtl/ccs_step.sv =====
// Input register, scanner state and per-byte result logic.
`timescale 1ns / 1ps

module ccs_step import ccs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        strings_aware_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  input  logic        room_i,
  output ccs_push_t   push_o
);

  typedef struct packed {
    ccs_state_t st;
    logic       emit;
  } ccs_plain_t;

  // One byte with no slash held.
  function automatic ccs_plain_t plain_byte(ccs_state_t s, logic sa, logic [7:0] c);
    ccs_plain_t p;
    p.st   = s;
    p.emit = 1'b0;
    if (sa && !s.ins && c == ChQuote && !s.line && !s.blk) begin
      p.st.ins = 1'b1;
      p.st.esc = 1'b0;
      p.emit   = 1'b1;
    end else if (sa && s.ins) begin
      if (c == ChQuote && !s.esc) p.st.ins = 1'b0;
      p.st.esc = (c == ChBslash) ? !s.esc : 1'b0;
      p.emit   = 1'b1;
    end else if (s.line) begin
      if (c == ChNl) p.st.line = 1'b0;
    end else if (s.blk) begin
      if (s.star && c == ChSlash) begin
        p.st.blk  = 1'b0;
        p.st.star = 1'b0;
      end else begin
        p.st.star = (c == ChStar);
      end
    end else if (c == ChSlash) begin
      p.st.held = 1'b1;
    end else begin
      p.emit = 1'b1;
    end
    return p;
  endfunction

  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        s1_last_q;
  ccs_state_t  st_q, st_d;
  logic        proc;
  ccs_push_t   res;

  assign proc       = s1_valid_q && room_i;
  assign in_ready_o = !s1_valid_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      st_q       <= '0;
    end else begin
      if (in_ready_o) s1_valid_q <= in_valid_i;
      if (proc) st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q <= in_byte_i;
      s1_last_q <= in_last_i;
    end
  end

  always_comb begin
    ccs_state_t  st;
    ccs_plain_t  p;
    logic        lead;
    logic        pe;
    logic        trail;
    logic        second;
    logic [7:0]  secb;
    st        = st_q;
    st.ins    = st_q.ins && strings_aware_i;
    st.esc    = st_q.esc && strings_aware_i;
    lead      = 1'b0;
    pe        = 1'b0;
    p         = '0;
    if (st.held) begin
      st.held = 1'b0;
      if (s1_byte_q == ChSlash) begin
        st.line = 1'b1;
      end else if (s1_byte_q == ChStar) begin
        st.blk  = 1'b1;
        st.star = 1'b0;
      end else begin
        lead = 1'b1;
        p    = plain_byte(st, strings_aware_i, s1_byte_q);
        st   = p.st;
        pe   = p.emit;
      end
    end else begin
      p  = plain_byte(st, strings_aware_i, s1_byte_q);
      st = p.st;
      pe = p.emit;
    end
    // a plain emit and a newly held slash exclude each other
    trail  = s1_last_q && st.held;
    second = pe || trail;
    secb   = pe ? s1_byte_q : ChSlash;

    res = '0;
    if (lead) begin
      res.r0 = '{data: ChSlash, byte_valid: 1'b1, eot: 1'b0};
      res.r1 = '{data: secb, byte_valid: 1'b1, eot: 1'b0};
      res.n  = second ? 2'd2 : 2'd1;
    end else if (second) begin
      res.r0 = '{data: secb, byte_valid: 1'b1, eot: 1'b0};
      res.n  = 2'd1;
    end else if (s1_last_q) begin
      // bare end marker
      res.r0 = '{data: 8'h00, byte_valid: 1'b0, eot: 1'b0};
      res.n  = 2'd1;
    end
    if (s1_last_q) begin
      if (res.n == 2'd2) res.r1.eot = 1'b1;
      else               res.r0.eot = 1'b1;
    end
    st_d = s1_last_q ? '0 : st;

    push_o   = res;
    push_o.n = proc ? res.n : 2'd0;
  end

`ifndef SYNTHESIS
  // State returns to reset after the final byte of a text.
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && s1_last_q |=> st_q == '0)
    else $error("state not cleared after last byte");

  // No results are pushed unless the queue has room for two.
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.n != 2'd0 |-> room_i)
    else $error("push without queue room");

  // The final byte always yields at least one result, ending in the marker flag.
  a_last_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && s1_last_q |-> push_o.n != 2'd0 &&
      ((push_o.n == 2'd1 && push_o.r0.eot) || (push_o.n == 2'd2 && push_o.r1.eot)))
    else $error("last byte without end-of-text result");
`endif

endmodule

// ===== rtl/ccs_outq.sv =====
// Small result queue taking up to two results a cycle, draining one.
`timescale 1ns / 1ps

module ccs_outq import ccs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ccs_push_t   push_i,
  output logic        room_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output ccs_result_t out_o
);

  ccs_result_t            ent_q [QDepth];
  logic [QPtrW-1:0]       wr_q, rd_q;
  logic [QCntW-1:0]       cnt_q;
  logic                   pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign out_o       = ent_q[rd_q];
  assign room_o      = (cnt_q <= QCntW'(QDepth - 2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + QPtrW'(push_i.n);
      if (pop) rd_q <= rd_q + QPtrW'(1);
      cnt_q <= cnt_q + QCntW'(push_i.n) - QCntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) ent_q[wr_q] <= push_i.r0;
    if (push_i.n == 2'd2) ent_q[wr_q + QPtrW'(1)] <= push_i.r1;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("queue overflow");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    QPtrW'(wr_q - rd_q) == cnt_q[QPtrW-1:0])
    else $error("queue pointers disagree with count");

  a_marker_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.byte_valid |-> out_o.eot && out_o.data == 8'h00)
    else $error("bare marker without end-of-text");
`endif

endmodule

// ===== tb/sv/c_comment_stripper_test.sv =====
// Self-checking testbench for the C/C++ comment stripper.
`timescale 1ns / 1ps

module c_comment_stripper_test import ccs_pkg::*;;

  // Cycles with no accepted request of any kind before the run is declared hung.
  localparam int StallLimit = 4000;
  // Quiet cycles after the last expected result before a config write or the end.
  localparam int DrainCycles = 8;
  // Random input bytes per idling phase.
  localparam int PhaseBytes = 610;

  // One stripped-text result as seen on the output port.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_text;
  } text_out_t;

  // Directed table: either a text byte or a strings_aware write.
  typedef enum logic {RowByte, RowCfg} row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    logic [7:0] value;     // text byte, or strings_aware in bit 0
    logic       last;
    logic       typed;     // 1: the single result below is the expectation
    text_out_t  exp;
  } dir_row_t;

  localparam text_out_t NoExp = '{8'h00, 1'b0, 1'b0};

  // Directed rows. Rows with typed = 1 carry a result that is obvious by
  // inspection; the rest go through the scanner mirror.
  dir_row_t dir_rows [0:29] = '{
    '{RowByte, 8'h41,   1'b0, 1'b1, '{8'h41, 1'b1, 1'b0}},   // first byte after reset
    '{RowByte, 8'h00,   1'b0, 1'b1, '{8'h00, 1'b1, 1'b0}},   // zero byte is ordinary
    '{RowByte, 8'hFF,   1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0}},   // top byte value
    '{RowByte, ChSlash, 1'b0, 1'b0, NoExp},                  // slash held
    '{RowByte, 8'h78,   1'b0, 1'b0, NoExp},                  // 'x': slash released, two results
    '{RowByte, ChSlash, 1'b0, 1'b0, NoExp},
    '{RowByte, ChSlash, 1'b0, 1'b0, NoExp},                  // line comment opens
    '{RowByte, 8'h41,   1'b0, 1'b0, NoExp},                  // dropped
    '{RowByte, ChNl,    1'b0, 1'b0, NoExp},                  // newline dropped, comment ends
    '{RowByte, ChSlash, 1'b0, 1'b0, NoExp},
    '{RowByte, ChStar,  1'b0, 1'b0, NoExp},                  // block comment opens
    '{RowByte, ChSlash, 1'b0, 1'b0, NoExp},                  // opening star does not close
    '{RowByte, ChStar,  1'b0, 1'b0, NoExp},
    '{RowByte, ChStar,  1'b0, 1'b0, NoExp},
    '{RowByte, ChSlash, 1'b0, 1'b0, NoExp},                  // closes after double star
    '{RowByte, ChQuote, 1'b0, 1'b0, NoExp},                  // string opens
    '{RowByte, ChSlash, 1'b0, 1'b0, NoExp},
    '{RowByte, ChSlash, 1'b0, 1'b0, NoExp},                  // kept inside string
    '{RowByte, ChBslash, 1'b0, 1'b0, NoExp},
    '{RowByte, ChQuote, 1'b0, 1'b0, NoExp},                  // escaped quote
    '{RowByte, ChQuote, 1'b0, 1'b0, NoExp},                  // string closes
    '{RowByte, ChSlash, 1'b1, 1'b1, '{ChSlash, 1'b1, 1'b1}}, // held slash flushed on last
    '{RowByte, ChSlash, 1'b0, 1'b0, NoExp},
    '{RowByte, ChStar,  1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}},   // nothing out: bare end marker
    '{RowByte, ChQuote, 1'b0, 1'b0, NoExp},                  // leave a string open
    '{RowCfg,  8'h00,   1'b0, 1'b0, NoExp},                  // strings off: string forgotten
    '{RowByte, ChSlash, 1'b0, 1'b0, NoExp},
    '{RowByte, ChSlash, 1'b0, 1'b0, NoExp},                  // now a real line comment
    '{RowByte, 8'h7A,   1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}},   // dropped, marker ends text
    '{RowCfg,  8'h01,   1'b0, 1'b0, NoExp}
  };

  // DUT ports; the inputs are at known values from time zero.
  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_strings_aware_i = 1'b1;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] in_byte_i = 8'h00;
  logic       in_last_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       byte_valid_o;
  logic       end_of_text_o;

  c_comment_stripper dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_strings_aware_i(cfg_strings_aware_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .in_byte_i          (in_byte_i),
    .in_last_i          (in_last_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .out_byte_o         (out_byte_o),
    .byte_valid_o       (byte_valid_o),
    .end_of_text_o      (end_of_text_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Idling odds in percent, set per phase by the stimulus thread.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  int unsigned err_count = 0;
  int unsigned quiet_cycles = 0;

  // Scanner mirror: register copy and per-text state.
  logic aware_mir = 1'b1;
  logic str_open = 1'b0;    // inside a double-quoted string
  logic esc_open = 1'b0;    // backslash seen inside string
  logic line_cmt = 1'b0;
  logic blk_cmt = 1'b0;
  logic slash_wait = 1'b0;  // a slash waits for the next byte
  logic star_prev = 1'b0;   // last block-comment byte was a star

  text_out_t step_res[$];      // results of the request being scanned
  text_out_t stripped_q[$];    // expected results, oldest first
  bit        typed_row_q[$];   // per queued request: expectation comes from the table
  text_out_t typed_exp_q[$];

  function automatic void emit(input logic [7:0] b, input logic v);
    text_out_t r;
    r.out_byte    = v ? b : 8'h00;
    r.byte_valid  = v;
    r.end_of_text = 1'b0;
    step_res.push_back(r);
  endfunction

  // One byte with no slash pending.
  function automatic void scan_plain(input logic [7:0] c);
    if (aware_mir && !str_open && c == ChQuote && !line_cmt && !blk_cmt) begin
      str_open = 1'b1;
      esc_open = 1'b0;
      emit(c, 1'b1);
    end else if (aware_mir && str_open) begin
      if (c == ChQuote && !esc_open) str_open = 1'b0;
      esc_open = (c == ChBslash) ? !esc_open : 1'b0;
      emit(c, 1'b1);
    end else if (line_cmt) begin
      if (c == ChNl) line_cmt = 1'b0;
    end else if (blk_cmt) begin
      if (star_prev && c == ChSlash) begin
        blk_cmt   = 1'b0;
        star_prev = 1'b0;
      end else begin
        star_prev = (c == ChStar);
      end
    end else if (c == ChSlash) begin
      slash_wait = 1'b1;
    end else begin
      emit(c, 1'b1);
    end
  endfunction

  // Predicted results of one accepted request, left in step_res.
  function automatic void strip_step(input logic [7:0] c, input logic last);
    text_out_t r;
    step_res.delete();
    // with strings off, any open string is forgotten
    if (!aware_mir) begin
      str_open = 1'b0;
      esc_open = 1'b0;
    end
    if (slash_wait) begin
      slash_wait = 1'b0;
      if (c == ChSlash) begin
        line_cmt = 1'b1;
      end else if (c == ChStar) begin
        blk_cmt   = 1'b1;
        star_prev = 1'b0;
      end else begin
        emit(ChSlash, 1'b1);
        scan_plain(c);
      end
    end else begin
      scan_plain(c);
    end
    if (last) begin
      if (slash_wait) emit(ChSlash, 1'b1);
      if (step_res.size() == 0) emit(8'h00, 1'b0);
      r = step_res.pop_back();
      r.end_of_text = 1'b1;
      step_res.push_back(r);
      str_open   = 1'b0;
      esc_open   = 1'b0;
      line_cmt   = 1'b0;
      blk_cmt    = 1'b0;
      slash_wait = 1'b0;
      star_prev  = 1'b0;
    end
  endfunction

  // Receiver: random backpressure, one assignment per edge.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: checks results, tracks config writes, predicts accepted requests.
  // Everything samples pre-edge values, so order within the step does not matter.
  always @(posedge clk_i) begin
    text_out_t got;
    text_out_t want;
    bit        from_table;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = '{out_byte_o, byte_valid_o, end_of_text_o};
        if (stripped_q.size() == 0) begin
          $error("result with nothing expected: out_byte %02h byte_valid %0b end_of_text %0b",
                 got.out_byte, got.byte_valid, got.end_of_text);
          err_count++;
        end else begin
          want = stripped_q.pop_front();
          if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
            err_count++;
          end
          if (got.byte_valid !== want.byte_valid) begin
            $error("byte_valid: expected %0b, got %0b", want.byte_valid, got.byte_valid);
            err_count++;
          end
          if (got.end_of_text !== want.end_of_text) begin
            $error("end_of_text: expected %0b, got %0b", want.end_of_text, got.end_of_text);
            err_count++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) aware_mir = cfg_strings_aware_i;
      if (in_valid_i && in_ready_o) begin
        strip_step(in_byte_i, in_last_i);
        from_table = typed_row_q.pop_front();
        if (from_table) begin
          stripped_q.push_back(typed_exp_q.pop_front());
        end else begin
          foreach (step_res[i]) stripped_q.push_back(step_res[i]);
        end
      end
    end
  end

  // Watchdog: any accepted request on any channel counts as progress.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("FAIL c_comment_stripper");
      $finish;
    end
  end

  // Offer one text byte; returns in the step where it is accepted, valid still high.
  task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
                           input text_out_t exp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    typed_row_q.push_back(typed);
    if (typed) typed_exp_q.push_back(exp);
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    in_last_i  <= last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stop sending and wait until every expected result is out, plus a margin
  // for bytes that produce nothing but may still be in the pipe.
  task automatic drain_text();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (stripped_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_aware(input logic v);
    cfg_valid_i         <= 1'b1;
    cfg_strings_aware_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Text bytes biased toward the characters the scanner reacts to.
  function automatic logic [7:0] pick_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 18) return ChSlash;
    if (r < 30) return ChStar;
    if (r < 40) return ChQuote;
    if (r < 46) return ChBslash;
    if (r < 54) return ChNl;
    if (r < 82) return 8'(8'h61 + $urandom_range(25));
    return 8'($urandom_range(255));
  endfunction

  initial begin
    int         len;
    int         sent;
    bit         noise;
    logic       lst;
    logic [7:0] b;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, sender and receiver both idling a little.
    send_idle_pct = 16;
    recv_idle_pct = 54;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == RowCfg) begin
        drain_text();
        write_aware(dir_rows[i].value[0]);
      end else begin
        send_byte(dir_rows[i].value, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].exp);
      end
    end

    // Random texts under three idling patterns. Mostly scanner-heavy text ending
    // in a last byte; about one text in ten is raw noise with stray last flags.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 16;
          recv_idle_pct = 54;
        end
        1: begin
          send_idle_pct = 54;
          recv_idle_pct = 16;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < PhaseBytes) begin
        if ($urandom_range(3) == 0) begin
          drain_text();
          write_aware(logic'($urandom_range(1)));
        end
        len   = $urandom_range(40, 1);
        noise = ($urandom_range(9) == 0);
        for (int k = 0; k < len; k++) begin
          b   = noise ? 8'($urandom_range(255)) : pick_char();
          lst = (k == len - 1) || (noise && $urandom_range(15) == 0);
          send_byte(b, lst, 1'b0, NoExp);
          sent++;
        end
      end
    end

    drain_text();
    if (err_count == 0 && stripped_q.size() == 0) begin
      $display("PASS c_comment_stripper");
    end else begin
      $display("FAIL c_comment_stripper");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ccs_pkg.sv
rtl/ccs_step.sv
rtl/ccs_outq.sv
rtl/c_comment_stripper.sv
tb/sv/c_comment_stripper_test.sv
